// ----- rtl/cpu_8080_subset_core_defines.svh -----
// Assertion helpers for the 8080 subset core
`ifndef CPU_8080_SUBSET_CORE_DEFINES_SVH
`define CPU_8080_SUBSET_CORE_DEFINES_SVH

// same-cycle implication
`define CPU8080_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cpu8080 check failed");

// next-cycle implication
`define CPU8080_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cpu8080 check failed");

`endif

// ----- rtl/cpu8080_pkg.sv -----
`default_nettype none
package cpu8080_pkg;

   localparam int MEM_DEPTH = 65536;
   localparam int MEM_AW    = $clog2(MEM_DEPTH);
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W    = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W    = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      ST_LOADED   = 2'd0,
      ST_EXECUTED = 2'd1,
      ST_HALTED   = 2'd2,
      ST_END      = 2'd3
   } status_type;

   typedef enum logic {
      CMD_LOAD = 1'b0,
      CMD_STEP = 1'b1
   } cmd_type;

   typedef struct packed {
      cmd_type     cmd;
      logic [15:0] address;
      logic [7:0]  data_byte;
   } item_type;

   typedef struct packed {
      logic [QCNT_W-1:0] count;
      logic              full;
   } front_stat_type;

   typedef struct packed {
      logic clearing;
   } exec_stat_type;

endpackage
`default_nettype wire

// ----- rtl/cpu8080_if.sv -----
`default_nettype none
interface cpu8080_req_if;
   logic        valid;
   logic        ready;
   logic        cmd;
   logic [15:0] address;
   logic [7:0]  data_byte;

   modport source (output valid, cmd, address, data_byte, input ready);
   modport sink (input valid, cmd, address, data_byte, output ready);
endinterface

interface cpu8080_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [15:0] prog_counter;
   logic [15:0] stack_ptr;
   logic [7:0]  reg_a;
   logic [7:0]  reg_b;
   logic [7:0]  reg_c;
   logic [7:0]  reg_d;
   logic [7:0]  reg_e;
   logic [7:0]  reg_h;
   logic [7:0]  reg_l;
   logic [4:0]  flag_bits;

   modport source (output valid, status, prog_counter, stack_ptr, reg_a, reg_b, reg_c,
                   reg_d, reg_e, reg_h, reg_l, flag_bits, input ready);
   modport sink (input valid, status, prog_counter, stack_ptr, reg_a, reg_b, reg_c,
                 reg_d, reg_e, reg_h, reg_l, flag_bits, output ready);
endinterface
`default_nettype wire

// ----- rtl/cpu8080_ram.sv -----
`default_nettype none
module cpu8080_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

// ----- rtl/cpu8080_front.sv -----
`default_nettype none
module cpu8080_front (
   input  wire logic                           clock,
   input  wire logic                           reset,
   cpu8080_req_if.sink                         req,
   input  wire cpu8080_pkg::exec_stat_type     exec_stat,
   input  wire logic                           q_pop,
   output logic                                q_valid,
   output cpu8080_pkg::item_type               q_item,
   output cpu8080_pkg::front_stat_type         front_stat
);
   cpu8080_pkg::item_type                    q_ff [cpu8080_pkg::QUEUE_DEPTH];
   logic [cpu8080_pkg::QPTR_W-1:0]           wr_ptr_ff, wr_ptr_in;
   logic [cpu8080_pkg::QPTR_W-1:0]           rd_ptr_ff, rd_ptr_in;
   logic [cpu8080_pkg::QCNT_W-1:0]           count_ff, count_in;
   logic                                     full;
   logic                                     push;
   logic                                     pop;
   cpu8080_pkg::item_type                    in_item;

   assign full     = (count_ff == cpu8080_pkg::QCNT_W'(cpu8080_pkg::QUEUE_DEPTH));
   assign req.ready = !full && !exec_stat.clearing;
   assign push     = req.valid && req.ready;
   assign q_valid  = (count_ff != '0);
   assign pop      = q_pop && q_valid;
   assign q_item   = q_ff[rd_ptr_ff];

   // classify the command bit into its code
   always_comb begin
      in_item.cmd       = req.cmd ? cpu8080_pkg::CMD_STEP : cpu8080_pkg::CMD_LOAD;
      in_item.address   = req.address;
      in_item.data_byte = req.data_byte;
   end

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         q_ff[wr_ptr_ff] <= in_item;
      end
   end

   assign front_stat.count = count_ff;
   assign front_stat.full  = full;
endmodule
`default_nettype wire

// ----- rtl/cpu8080_exec.sv -----
`default_nettype none
module cpu8080_exec (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        q_valid,
   input  wire cpu8080_pkg::item_type       q_item,
   output logic                             q_pop,
   input  wire logic [16:0]                 program_length,
   cpu8080_rsp_if.source                    rsp,
   output cpu8080_pkg::exec_stat_type       exec_stat
);
   localparam int AW = cpu8080_pkg::MEM_AW;

   localparam logic [7:0] OP_ADI   = 8'hC6;
   localparam logic [7:0] OP_SBI   = 8'hDE;
   localparam logic [7:0] OP_INXB  = 8'h03;
   localparam logic [7:0] OP_INXD  = 8'h13;
   localparam logic [7:0] OP_INXH  = 8'h23;
   localparam logic [7:0] OP_INXSP = 8'h33;
   localparam logic [7:0] OP_MOVDM = 8'h56;
   localparam logic [7:0] OP_MOVEM = 8'h5E;
   localparam logic [7:0] OP_MOVHM = 8'h66;
   localparam logic [7:0] OP_MOVLA = 8'h6F;
   localparam logic [7:0] OP_MOVMA = 8'h77;
   localparam logic [7:0] OP_MOVAD = 8'h7A;
   localparam logic [7:0] OP_MOVAE = 8'h7B;
   localparam logic [7:0] OP_MOVAH = 8'h7C;
   localparam logic [7:0] OP_MOVAM = 8'h7E;
   localparam logic [7:0] OP_MVIB  = 8'h06;
   localparam logic [7:0] OP_MVIC  = 8'h0E;
   localparam logic [7:0] OP_MVID  = 8'h16;
   localparam logic [7:0] OP_MVIE  = 8'h1E;
   localparam logic [7:0] OP_MVIH  = 8'h26;
   localparam logic [7:0] OP_MVIL  = 8'h2E;
   localparam logic [7:0] OP_MVIM  = 8'h36;
   localparam logic [7:0] OP_MVIA  = 8'h3E;
   localparam logic [7:0] OP_LXIB  = 8'h01;
   localparam logic [7:0] OP_LXID  = 8'h11;
   localparam logic [7:0] OP_LXIH  = 8'h21;
   localparam logic [7:0] OP_LXISP = 8'h31;
   localparam logic [7:0] OP_STA   = 8'h32;
   localparam logic [7:0] OP_JMP   = 8'hC3;
   localparam logic [7:0] OP_JNZ   = 8'hC2;
   localparam logic [7:0] OP_RET   = 8'hC9;
   localparam logic [7:0] OP_POPB  = 8'hC1;
   localparam logic [7:0] OP_POPD  = 8'hD1;
   localparam logic [7:0] OP_POPH  = 8'hE1;
   localparam logic [7:0] OP_PUSHB = 8'hC5;
   localparam logic [7:0] OP_PUSHD = 8'hD5;
   localparam logic [7:0] OP_PUSHH = 8'hE5;
   localparam logic [7:0] OP_SPHL  = 8'hF9;
   localparam logic [7:0] OP_EI    = 8'hFB;
   localparam logic [7:0] OP_DI    = 8'hF3;
   localparam logic [7:0] OP_HLT   = 8'h76;
   localparam logic [4:0] GRP_ADD  = 5'b10000;
   localparam logic [4:0] GRP_SUB  = 5'b10010;
   localparam logic [4:0] GRP_ANA  = 5'b10100;
   localparam logic [1:0] PAIR_BC  = 2'd0;
   localparam logic [1:0] PAIR_DE  = 2'd1;
   localparam logic [2:0] SRC_B = 3'd0;
   localparam logic [2:0] SRC_C = 3'd1;
   localparam logic [2:0] SRC_D = 3'd2;
   localparam logic [2:0] SRC_E = 3'd3;
   localparam logic [2:0] SRC_H = 3'd4;
   localparam logic [2:0] SRC_L = 3'd5;
   localparam logic [2:0] SRC_M = 3'd6;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_F1, S_F2, S_F3, S_P1, S_W2, S_EX, S_OUT
   } state_type;

   state_type                 state_ff;
   logic [AW-1:0]             clr_ptr_ff;
   logic [15:0]               pc_ff, sp_ff;
   logic [7:0]                a_ff, b_ff, c_ff, d_ff, e_ff, h_ff, l_ff;
   logic [4:0]                flags_ff;
   logic                      ie_ff;
   logic                      halted_ff;
   logic [7:0]                op_ff, b1_ff, b2_ff, lo_ff;
   cpu8080_pkg::status_type   status_ff;
   logic                      rsp_valid_ff;
   logic [1:0]                rsp_status_ff;
   logic [15:0]               rsp_pc_ff, rsp_sp_ff;
   logic [7:0]                rsp_a_ff, rsp_b_ff, rsp_c_ff, rsp_d_ff;
   logic [7:0]                rsp_e_ff, rsp_h_ff, rsp_l_ff;
   logic [4:0]                rsp_flags_ff;

   logic                      ram_we;
   logic [AW-1:0]             ram_addr;
   logic [7:0]                ram_wd;
   logic [7:0]                ram_rd;
   logic [15:0]               hl;
   logic [15:0]               word;
   logic [15:0]               pc_p1, pc_p2, sp_p1, sp_m1, sp_m2, sta_addr;
   logic [7:0]                src_val, alu_v;
   logic                      alu_bin;
   logic [8:0]                add9, sub9;
   logic [7:0]                and8;
   logic [7:0]                push_hi, push_lo;
   logic                      is_pop, is_push;
   logic                      out_free;

   function automatic logic [4:0] flags_of(input logic [7:0] r, input logic cy);
      return {r[7], (r == 8'h00), 1'b0, ~^r, cy};
   endfunction

   cpu8080_ram #(.WIDTH(8), .DEPTH(cpu8080_pkg::MEM_DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .addr    (ram_addr),
      .wr_data (ram_wd),
      .rd_data (ram_rd)
   );

   assign hl      = {h_ff, l_ff};
   assign word    = {b2_ff, b1_ff};
   assign pc_p1   = pc_ff + 16'd1;
   assign pc_p2   = pc_ff + 16'd2;
   assign sp_p1   = sp_ff + 16'd1;
   assign sp_m1   = sp_ff - 16'd1;
   assign sp_m2   = sp_ff - 16'd2;
   // high address byte is on the read port in state S_F3
   assign sta_addr = {ram_rd, b1_ff};
   assign is_pop  = (op_ff == OP_POPB) || (op_ff == OP_POPD) || (op_ff == OP_POPH)
                    || (op_ff == OP_RET);
   assign is_push = (op_ff == OP_PUSHB) || (op_ff == OP_PUSHD) || (op_ff == OP_PUSHH);
   assign out_free = !rsp_valid_ff || rsp.ready;
   assign q_pop   = (state_ff == S_IDLE) && q_valid;
   assign exec_stat.clearing = (state_ff == S_CLEAR);

   always_comb begin
      case (op_ff[5:4])
         PAIR_BC: begin
            push_hi = b_ff;
            push_lo = c_ff;
         end
         PAIR_DE: begin
            push_hi = d_ff;
            push_lo = e_ff;
         end
         default: begin
            push_hi = h_ff;
            push_lo = l_ff;
         end
      endcase
   end

   // ALU operand: register, the byte read at HL, or the immediate byte for ADI and SBI
   always_comb begin
      case (op_ff[2:0])
         SRC_B:   src_val = b_ff;
         SRC_C:   src_val = c_ff;
         SRC_D:   src_val = d_ff;
         SRC_E:   src_val = e_ff;
         SRC_H:   src_val = h_ff;
         SRC_L:   src_val = l_ff;
         SRC_M:   src_val = ram_rd;
         default: src_val = a_ff;
      endcase
      alu_v   = ((op_ff == OP_ADI) || (op_ff == OP_SBI)) ? b1_ff : src_val;
      alu_bin = (op_ff == OP_SBI) ? flags_ff[0] : 1'b0;
      add9    = {1'b0, a_ff} + {1'b0, alu_v};
      sub9    = {1'b0, a_ff} - {1'b0, alu_v} - {8'h00, alu_bin};
      and8    = a_ff & alu_v;
   end

   always_comb begin
      ram_we   = 1'b0;
      ram_addr = pc_ff[AW-1:0];
      ram_wd   = 8'h00;
      case (state_ff)
         S_CLEAR: begin
            ram_we   = 1'b1;
            ram_addr = clr_ptr_ff;
         end
         S_IDLE: begin
            if (q_valid && (q_item.cmd == cpu8080_pkg::CMD_LOAD)) begin
               ram_we   = 1'b1;
               ram_addr = q_item.address[AW-1:0];
               ram_wd   = q_item.data_byte;
            end
         end
         S_F1: ram_addr = pc_p1[AW-1:0];
         S_F2: ram_addr = pc_p2[AW-1:0];
         S_F3: begin
            if (is_pop) begin
               ram_addr = sp_ff[AW-1:0];
            end else if (is_push) begin
               ram_we   = 1'b1;
               ram_addr = sp_m1[AW-1:0];
               ram_wd   = push_hi;
            end else if (op_ff == OP_MOVMA) begin
               ram_we   = 1'b1;
               ram_addr = hl[AW-1:0];
               ram_wd   = a_ff;
            end else if (op_ff == OP_MVIM) begin
               ram_we   = 1'b1;
               ram_addr = hl[AW-1:0];
               ram_wd   = b1_ff;
            end else if (op_ff == OP_STA) begin
               ram_we   = 1'b1;
               ram_addr = sta_addr[AW-1:0];
               ram_wd   = a_ff;
            end else begin
               ram_addr = hl[AW-1:0];
            end
         end
         S_P1: ram_addr = sp_p1[AW-1:0];
         S_W2: begin
            ram_we   = 1'b1;
            ram_addr = sp_m2[AW-1:0];
            ram_wd   = push_lo;
         end
         default: ram_addr = pc_ff[AW-1:0];
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ptr_ff   <= '0;
         pc_ff        <= '0;
         sp_ff        <= '0;
         a_ff         <= '0;
         b_ff         <= '0;
         c_ff         <= '0;
         d_ff         <= '0;
         e_ff         <= '0;
         h_ff         <= '0;
         l_ff         <= '0;
         flags_ff     <= '0;
         ie_ff        <= 1'b0;
         halted_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         status_ff    <= cpu8080_pkg::ST_LOADED;
      end else begin
         if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_CLEAR: begin
               clr_ptr_ff <= clr_ptr_ff + 1'b1;
               if (clr_ptr_ff == '1) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (q_valid) begin
                  if (q_item.cmd == cpu8080_pkg::CMD_LOAD) begin
                     status_ff <= cpu8080_pkg::ST_LOADED;
                     state_ff  <= S_OUT;
                  end else if (halted_ff) begin
                     status_ff <= cpu8080_pkg::ST_HALTED;
                     state_ff  <= S_OUT;
                  end else if ({1'b0, pc_ff} >= program_length) begin
                     status_ff <= cpu8080_pkg::ST_END;
                     state_ff  <= S_OUT;
                  end else begin
                     state_ff <= S_F1;
                  end
               end
            end
            S_F1: begin
               op_ff    <= ram_rd;
               state_ff <= S_F2;
            end
            S_F2: begin
               b1_ff    <= ram_rd;
               state_ff <= S_F3;
            end
            S_F3: begin
               b2_ff <= ram_rd;
               if (is_pop) begin
                  state_ff <= S_P1;
               end else if (is_push) begin
                  state_ff <= S_W2;
               end else begin
                  state_ff <= S_EX;
               end
            end
            S_P1: begin
               lo_ff    <= ram_rd;
               state_ff <= S_EX;
            end
            S_W2: state_ff <= S_EX;
            S_EX: begin
               status_ff <= cpu8080_pkg::ST_EXECUTED;
               state_ff  <= S_OUT;
               pc_ff     <= pc_ff + 16'd1;
               if (op_ff[7:3] == GRP_ADD) begin
                  a_ff     <= add9[7:0];
                  flags_ff <= flags_of(add9[7:0], add9[8]);
               end else if (op_ff[7:3] == GRP_SUB) begin
                  a_ff     <= sub9[7:0];
                  flags_ff <= flags_of(sub9[7:0], sub9[8]);
               end else if (op_ff[7:3] == GRP_ANA) begin
                  a_ff     <= and8;
                  flags_ff <= flags_of(and8, 1'b0);
               end else begin
                  case (op_ff)
                     OP_ADI: begin
                        a_ff     <= add9[7:0];
                        flags_ff <= flags_of(add9[7:0], add9[8]);
                        pc_ff    <= pc_ff + 16'd2;
                     end
                     OP_SBI: begin
                        a_ff     <= sub9[7:0];
                        flags_ff <= flags_of(sub9[7:0], sub9[8]);
                        pc_ff    <= pc_ff + 16'd2;
                     end
                     OP_INXB:  {b_ff, c_ff} <= {b_ff, c_ff} + 16'd1;
                     OP_INXD:  {d_ff, e_ff} <= {d_ff, e_ff} + 16'd1;
                     OP_INXH:  {h_ff, l_ff} <= hl + 16'd1;
                     OP_INXSP: sp_ff <= sp_ff + 16'd1;
                     OP_MOVDM: d_ff <= ram_rd;
                     OP_MOVEM: e_ff <= ram_rd;
                     OP_MOVHM: h_ff <= ram_rd;
                     OP_MOVLA: l_ff <= a_ff;
                     OP_MOVAD: a_ff <= d_ff;
                     OP_MOVAE: a_ff <= e_ff;
                     OP_MOVAH: a_ff <= h_ff;
                     OP_MOVAM: a_ff <= ram_rd;
                     OP_MVIB: begin
                        b_ff  <= b1_ff;
                        pc_ff <= pc_ff + 16'd2;
                     end
                     OP_MVIC: begin
                        c_ff  <= b1_ff;
                        pc_ff <= pc_ff + 16'd2;
                     end
                     OP_MVID: begin
                        d_ff  <= b1_ff;
                        pc_ff <= pc_ff + 16'd2;
                     end
                     OP_MVIE: begin
                        e_ff  <= b1_ff;
                        pc_ff <= pc_ff + 16'd2;
                     end
                     OP_MVIH: begin
                        h_ff  <= b1_ff;
                        pc_ff <= pc_ff + 16'd2;
                     end
                     OP_MVIL: begin
                        l_ff  <= b1_ff;
                        pc_ff <= pc_ff + 16'd2;
                     end
                     OP_MVIM:  pc_ff <= pc_ff + 16'd2;
                     OP_MVIA: begin
                        a_ff  <= b1_ff;
                        pc_ff <= pc_ff + 16'd2;
                     end
                     OP_LXIB: begin
                        {b_ff, c_ff} <= word;
                        pc_ff        <= pc_ff + 16'd3;
                     end
                     OP_LXID: begin
                        {d_ff, e_ff} <= word;
                        pc_ff        <= pc_ff + 16'd3;
                     end
                     OP_LXIH: begin
                        {h_ff, l_ff} <= word;
                        pc_ff        <= pc_ff + 16'd3;
                     end
                     OP_LXISP: begin
                        sp_ff <= word;
                        pc_ff <= pc_ff + 16'd3;
                     end
                     OP_STA:  pc_ff <= pc_ff + 16'd3;
                     OP_JMP:  pc_ff <= word;
                     OP_JNZ:  pc_ff <= flags_ff[3] ? pc_ff + 16'd3 : word;
                     OP_RET: begin
                        pc_ff <= {ram_rd, lo_ff};
                        sp_ff <= sp_ff + 16'd2;
                     end
                     OP_POPB: begin
                        {b_ff, c_ff} <= {ram_rd, lo_ff};
                        sp_ff        <= sp_ff + 16'd2;
                     end
                     OP_POPD: begin
                        {d_ff, e_ff} <= {ram_rd, lo_ff};
                        sp_ff        <= sp_ff + 16'd2;
                     end
                     OP_POPH: begin
                        {h_ff, l_ff} <= {ram_rd, lo_ff};
                        sp_ff        <= sp_ff + 16'd2;
                     end
                     OP_PUSHB, OP_PUSHD, OP_PUSHH: sp_ff <= sp_ff - 16'd2;
                     OP_SPHL: sp_ff <= hl;
                     OP_EI:   ie_ff <= 1'b1;
                     OP_DI:   ie_ff <= 1'b0;
                     OP_HLT: begin
                        halted_ff <= 1'b1;
                        status_ff <= cpu8080_pkg::ST_HALTED;
                     end
                     default: pc_ff <= pc_ff + 16'd1;
                  endcase
               end
            end
            S_OUT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // capture the architectural state into the result register
   always_ff @(posedge clock) begin
      if ((state_ff == S_OUT) && out_free) begin
         rsp_status_ff <= status_ff;
         rsp_pc_ff     <= pc_ff;
         rsp_sp_ff     <= sp_ff;
         rsp_a_ff      <= a_ff;
         rsp_b_ff      <= b_ff;
         rsp_c_ff      <= c_ff;
         rsp_d_ff      <= d_ff;
         rsp_e_ff      <= e_ff;
         rsp_h_ff      <= h_ff;
         rsp_l_ff      <= l_ff;
         rsp_flags_ff  <= {flags_ff[4:3], ie_ff & 1'b0, flags_ff[1:0]};
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.status       = rsp_status_ff;
   assign rsp.prog_counter = rsp_pc_ff;
   assign rsp.stack_ptr    = rsp_sp_ff;
   assign rsp.reg_a        = rsp_a_ff;
   assign rsp.reg_b        = rsp_b_ff;
   assign rsp.reg_c        = rsp_c_ff;
   assign rsp.reg_d        = rsp_d_ff;
   assign rsp.reg_e        = rsp_e_ff;
   assign rsp.reg_h        = rsp_h_ff;
   assign rsp.reg_l        = rsp_l_ff;
   assign rsp.flag_bits    = rsp_flags_ff;
endmodule
`default_nettype wire

// ----- rtl/cpu_8080_subset_core.sv -----
// A load goes from the queue through S_OUT to the result register; a step goes through
// S_F1, S_F2, S_F3 (and S_P1 or S_W2 for PUSH, POP, RET), S_EX, S_OUT; halted or past-end
// steps go straight to S_OUT. The single-port program memory makes one access per cycle:
// three instruction byte reads plus one operand access per step (two for PUSH, POP, RET).
// A 2-entry queue keeps accepting until full. Reset is synchronous; afterward a pass over
// all MEM_DEPTH addresses zeroes memory and req_chan.ready stays low until it finishes.
`default_nettype none
`include "cpu_8080_subset_core_defines.svh"
module cpu_8080_subset_core (
   input  wire logic        clock,
   input  wire logic        reset,
   cpu8080_req_if.sink      req_chan,
   cpu8080_rsp_if.source    rsp_chan,
   input  wire logic        csr_wr_en,
   input  wire logic [16:0] csr_wr_data
);
   logic [16:0]                  program_length_ff;
   logic                         q_valid;
   logic                         q_pop;
   cpu8080_pkg::item_type        q_item;
   cpu8080_pkg::front_stat_type  front_stat;
   cpu8080_pkg::exec_stat_type   exec_stat;

   always_ff @(posedge clock) begin
      if (reset) begin
         program_length_ff <= '0;
      end else if (csr_wr_en) begin
         program_length_ff <= csr_wr_data;
      end
   end

   cpu8080_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .exec_stat  (exec_stat),
      .q_pop      (q_pop),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .front_stat (front_stat)
   );

   cpu8080_exec u_exec (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_item         (q_item),
      .q_pop          (q_pop),
      .program_length (program_length_ff),
      .rsp            (rsp_chan),
      .exec_stat      (exec_stat)
   );

   `CPU8080_ASSERT_NOW(a_no_accept_in_clear, clock, reset, exec_stat.clearing, !req_chan.ready)
   `CPU8080_ASSERT_NOW(a_queue_empty_in_clear, clock, reset, exec_stat.clearing, !q_valid)
   `CPU8080_ASSERT_NOW(a_full_blocks, clock, reset, front_stat.full, !req_chan.ready)
   `CPU8080_ASSERT_NEXT(a_no_overfill, clock, reset, front_stat.full && !q_pop, front_stat.full)
endmodule
`default_nettype wire

// ----- tb/cpu8080_opcode_pkg.sv -----
`timescale 1ns / 100ps
package cpu8080_opcode_pkg;

   localparam logic [7:0] OP_NOP    = 8'h00;
   localparam logic [7:0] OP_LXI_B  = 8'h01;
   localparam logic [7:0] OP_INX_B  = 8'h03;
   localparam logic [7:0] OP_MVI_B  = 8'h06;
   localparam logic [7:0] OP_MVI_C  = 8'h0E;
   localparam logic [7:0] OP_LXI_D  = 8'h11;
   localparam logic [7:0] OP_INX_D  = 8'h13;
   localparam logic [7:0] OP_MVI_D  = 8'h16;
   localparam logic [7:0] OP_MVI_E  = 8'h1E;
   localparam logic [7:0] OP_LXI_H  = 8'h21;
   localparam logic [7:0] OP_INX_H  = 8'h23;
   localparam logic [7:0] OP_MVI_H  = 8'h26;
   localparam logic [7:0] OP_MVI_L  = 8'h2E;
   localparam logic [7:0] OP_LXI_SP = 8'h31;
   localparam logic [7:0] OP_STA    = 8'h32;
   localparam logic [7:0] OP_INX_SP = 8'h33;
   localparam logic [7:0] OP_MVI_M  = 8'h36;
   localparam logic [7:0] OP_MVI_A  = 8'h3E;
   localparam logic [7:0] OP_MOV_DM = 8'h56;
   localparam logic [7:0] OP_MOV_EM = 8'h5E;
   localparam logic [7:0] OP_MOV_HM = 8'h66;
   localparam logic [7:0] OP_MOV_LA = 8'h6F;
   localparam logic [7:0] OP_HLT    = 8'h76;
   localparam logic [7:0] OP_MOV_MA = 8'h77;
   localparam logic [7:0] OP_MOV_AD = 8'h7A;
   localparam logic [7:0] OP_MOV_AE = 8'h7B;
   localparam logic [7:0] OP_MOV_AH = 8'h7C;
   localparam logic [7:0] OP_MOV_AM = 8'h7E;
   localparam logic [7:0] OP_ADD_B  = 8'h80;
   localparam logic [7:0] OP_SUB_B  = 8'h90;
   localparam logic [7:0] OP_ANA_B  = 8'hA0;
   localparam logic [7:0] OP_XRA_D  = 8'hAA;
   localparam logic [7:0] OP_POP_B  = 8'hC1;
   localparam logic [7:0] OP_JNZ    = 8'hC2;
   localparam logic [7:0] OP_JMP    = 8'hC3;
   localparam logic [7:0] OP_PUSH_B = 8'hC5;
   localparam logic [7:0] OP_ADI    = 8'hC6;
   localparam logic [7:0] OP_RET    = 8'hC9;
   localparam logic [7:0] OP_POP_D  = 8'hD1;
   localparam logic [7:0] OP_OUT    = 8'hD3;
   localparam logic [7:0] OP_PUSH_D = 8'hD5;
   localparam logic [7:0] OP_SBI    = 8'hDE;
   localparam logic [7:0] OP_POP_H  = 8'hE1;
   localparam logic [7:0] OP_PUSH_H = 8'hE5;
   localparam logic [7:0] OP_DI     = 8'hF3;
   localparam logic [7:0] OP_SPHL   = 8'hF9;
   localparam logic [7:0] OP_EI     = 8'hFB;

   // ALU group select in opcode bits 7:3
   localparam logic [4:0] GRP_ADD = 5'b10000;
   localparam logic [4:0] GRP_SUB = 5'b10010;
   localparam logic [4:0] GRP_ANA = 5'b10100;

endpackage

// ----- tb/cpu8080_result_checker.sv -----
`timescale 1ns / 100ps
module cpu8080_result_checker
   import cpu8080_pkg::*;
   import cpu8080_opcode_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   cpu8080_req_if      req,
   cpu8080_rsp_if      rsp,
   input  logic        csr_wr_en,
   input  logic [16:0] csr_wr_data,
   output int          err_count,
   output int          checked_count
);

   typedef struct {
      status_type  status;
      logic [15:0] pc;
      logic [15:0] sp;
      logic [7:0]  a, b, c, d, e, h, l;
      logic [4:0]  flags;
   } cpu_view_type;

   cpu_view_type pending_views[$];

   logic [7:0]  mem [0:65535];
   logic [15:0] pc, sp;
   logic [7:0]  ra, rb, rc, rd, re, rh, rl;
   logic [4:0]  fl;
   logic        int_en, halted;
   logic [16:0] prog_len;

   function automatic logic [15:0] hl();
      return {rh, rl};
   endfunction

   function automatic void set_flags(logic [7:0] r, logic cy);
      fl = {r[7], r == 8'd0, 1'b0, ~^r, cy};
   endfunction

   function automatic logic [7:0] src_val(logic [2:0] s);
      case (s)
         3'd0: return rb;
         3'd1: return rc;
         3'd2: return rd;
         3'd3: return re;
         3'd4: return rh;
         3'd5: return rl;
         3'd6: return mem[hl()];
         default: return ra;
      endcase
   endfunction

   function automatic void alu_sub(logic [7:0] v, logic bw);
      logic [8:0] diff;
      diff = {1'b0, ra} - {1'b0, v} - {8'd0, bw};
      ra = diff[7:0];
      set_flags(ra, diff[8]);
   endfunction

   function automatic void alu_add(logic [7:0] v);
      logic [8:0] sum;
      sum = {1'b0, ra} + {1'b0, v};
      ra = sum[7:0];
      set_flags(ra, sum[8]);
   endfunction

   function automatic void push_pair(logic [7:0] hi, logic [7:0] lo);
      logic [15:0] a1, a2;
      a1 = sp - 16'd1;
      a2 = sp - 16'd2;
      mem[a1] = hi;
      mem[a2] = lo;
      sp = a2;
   endfunction

   function automatic logic [15:0] pop_word();
      logic [15:0] a1;
      a1 = sp + 16'd1;
      pop_word = {mem[a1], mem[sp]};
      sp = sp + 16'd2;
   endfunction

   function automatic status_type run_op();
      logic [7:0]  op, b1, b2;
      logic [15:0] p1, p2, word, pair;
      logic [15:0] len;
      p1 = pc + 16'd1;
      p2 = pc + 16'd2;
      op = mem[pc];
      b1 = mem[p1];
      b2 = mem[p2];
      word = {b2, b1};
      len = 16'd1;
      if (op[7:3] == GRP_ADD) begin
         alu_add(src_val(op[2:0]));
      end else if (op[7:3] == GRP_SUB) begin
         alu_sub(src_val(op[2:0]), 1'b0);
      end else if (op[7:3] == GRP_ANA) begin
         ra = ra & src_val(op[2:0]);
         set_flags(ra, 1'b0);
      end else begin
         case (op)
            OP_ADI: begin alu_add(b1); len = 16'd2; end
            OP_SBI: begin alu_sub(b1, fl[0]); len = 16'd2; end
            OP_INX_B: begin pair = {rb, rc} + 16'd1; {rb, rc} = pair; end
            OP_INX_D: begin pair = {rd, re} + 16'd1; {rd, re} = pair; end
            OP_INX_H: begin pair = {rh, rl} + 16'd1; {rh, rl} = pair; end
            OP_INX_SP: sp = sp + 16'd1;
            OP_MOV_DM: rd = mem[hl()];
            OP_MOV_EM: re = mem[hl()];
            OP_MOV_HM: rh = mem[hl()];
            OP_MOV_LA: rl = ra;
            OP_MOV_MA: mem[hl()] = ra;
            OP_MOV_AD: ra = rd;
            OP_MOV_AE: ra = re;
            OP_MOV_AH: ra = rh;
            OP_MOV_AM: ra = mem[hl()];
            OP_MVI_B: begin rb = b1; len = 16'd2; end
            OP_MVI_C: begin rc = b1; len = 16'd2; end
            OP_MVI_D: begin rd = b1; len = 16'd2; end
            OP_MVI_E: begin re = b1; len = 16'd2; end
            OP_MVI_H: begin rh = b1; len = 16'd2; end
            OP_MVI_L: begin rl = b1; len = 16'd2; end
            OP_MVI_M: begin mem[hl()] = b1; len = 16'd2; end
            OP_MVI_A: begin ra = b1; len = 16'd2; end
            OP_LXI_B: begin {rb, rc} = word; len = 16'd3; end
            OP_LXI_D: begin {rd, re} = word; len = 16'd3; end
            OP_LXI_H: begin {rh, rl} = word; len = 16'd3; end
            OP_LXI_SP: begin sp = word; len = 16'd3; end
            OP_STA: begin mem[word] = ra; len = 16'd3; end
            OP_JMP: begin pc = word; return ST_EXECUTED; end
            OP_JNZ: begin
               if (!fl[3]) begin
                  pc = word;
                  return ST_EXECUTED;
               end
               len = 16'd3;
            end
            OP_RET: begin pc = pop_word(); return ST_EXECUTED; end
            OP_POP_B: {rb, rc} = pop_word();
            OP_POP_D: {rd, re} = pop_word();
            OP_POP_H: {rh, rl} = pop_word();
            OP_PUSH_B: push_pair(rb, rc);
            OP_PUSH_D: push_pair(rd, re);
            OP_PUSH_H: push_pair(rh, rl);
            OP_SPHL: sp = hl();
            OP_EI: int_en = 1'b1;
            OP_DI: int_en = 1'b0;
            OP_HLT: begin
               halted = 1'b1;
               pc = pc + 16'd1;
               return ST_HALTED;
            end
            default: ;
         endcase
      end
      pc = pc + len;
      return ST_EXECUTED;
   endfunction

   function automatic cpu_view_type predict_item(logic cmd, logic [15:0] adr,
                                                 logic [7:0] data);
      cpu_view_type v;
      if (cmd == CMD_LOAD) begin
         mem[adr] = data;
         v.status = ST_LOADED;
      end else if (halted) begin
         v.status = ST_HALTED;
      end else if ({1'b0, pc} >= prog_len) begin
         v.status = ST_END;
      end else begin
         v.status = run_op();
      end
      v.pc = pc; v.sp = sp; v.flags = fl;
      v.a = ra; v.b = rb; v.c = rc; v.d = rd; v.e = re; v.h = rh; v.l = rl;
      return v;
   endfunction

   function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         err_count++;
      end
   endfunction

   always @(posedge clock) begin
      cpu_view_type want;
      if (reset) begin
         foreach (mem[i]) mem[i] = 8'd0;
         pc = '0; sp = '0; fl = '0; int_en = 1'b0; halted = 1'b0; prog_len = '0;
         ra = '0; rb = '0; rc = '0; rd = '0; re = '0; rh = '0; rl = '0;
         err_count = 0;
         checked_count = 0;
         pending_views.delete();
      end else begin
         if (csr_wr_en) prog_len = csr_wr_data;
         if (rsp.valid && rsp.ready) begin
            if (pending_views.size() == 0) begin
               $error("result transfer with no expectation pending");
               err_count++;
            end else begin
               want = pending_views.pop_front();
               check_field("status", want.status, rsp.status);
               check_field("prog_counter", want.pc, rsp.prog_counter);
               check_field("stack_ptr", want.sp, rsp.stack_ptr);
               check_field("reg_a", want.a, rsp.reg_a);
               check_field("reg_b", want.b, rsp.reg_b);
               check_field("reg_c", want.c, rsp.reg_c);
               check_field("reg_d", want.d, rsp.reg_d);
               check_field("reg_e", want.e, rsp.reg_e);
               check_field("reg_h", want.h, rsp.reg_h);
               check_field("reg_l", want.l, rsp.reg_l);
               check_field("flag_bits", want.flags, rsp.flag_bits);
               checked_count++;
            end
         end
         if (req.valid && req.ready)
            pending_views.push_back(predict_item(req.cmd, req.address, req.data_byte));
      end
   end

endmodule

// ----- tb/cpu_8080_subset_core_test.sv -----
`timescale 1ns / 100ps
module cpu_8080_subset_core_test;
   import cpu8080_pkg::*;
   import cpu8080_opcode_pkg::*;

   localparam int IDLE_LIMIT = 200000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en;
   logic [16:0] csr_wr_data;
   int          err_count, checked_count;
   int          sent_count, recv_count, program_count;
   int          idle_cycles = 0;
   bit          fast_mode, hold_rsp;
   logic [15:0] last_pc;

   cpu8080_req_if req_chan ();
   cpu8080_rsp_if rsp_chan ();

   cpu_8080_subset_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .rsp_chan   (rsp_chan),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   cpu8080_result_checker checker_i (
      .clock        (clock),
      .reset        (reset),
      .req          (req_chan),
      .rsp          (rsp_chan),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .err_count    (err_count),
      .checked_count(checked_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // watchdog: covers the memory clearing pass after reset
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("[cpu_8080_subset_core] ERROR");
         $finish;
      end
   end

   task automatic send(cmd_type c, logic [15:0] adr, logic [7:0] data);
      int gap;
      gap = fast_mode ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.cmd       <= c;
      req_chan.address   <= adr;
      req_chan.data_byte <= data;
      do @(posedge clock); while (!req_chan.ready);
      sent_count++;
   endtask

   // drain all results, then let the core go quiet
   task automatic settle();
      req_chan.valid <= 1'b0;
      while (recv_count != sent_count) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_len(int len);
      settle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= len[16:0];
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   function automatic logic [7:0] pick_op();
      logic [7:0] op;
      case ($urandom_range(0, 47))
         0: op = OP_NOP;     1: op = OP_LXI_B;   2: op = OP_INX_B;   3: op = OP_MVI_B;
         4: op = OP_MVI_C;   5: op = OP_LXI_D;   6: op = OP_INX_D;   7: op = OP_MVI_D;
         8: op = OP_MVI_E;   9: op = OP_LXI_H;   10: op = OP_INX_H;  11: op = OP_MVI_H;
         12: op = OP_MVI_L;  13: op = OP_LXI_SP; 14: op = OP_STA;    15: op = OP_INX_SP;
         16: op = OP_MVI_M;  17: op = OP_MVI_A;  18: op = OP_MOV_DM; 19: op = OP_MOV_EM;
         20: op = OP_MOV_HM; 21: op = OP_MOV_LA; 22: op = OP_MOV_MA; 23: op = OP_MOV_AD;
         24: op = OP_MOV_AE; 25: op = OP_MOV_AH; 26: op = OP_MOV_AM; 27: op = OP_XRA_D;
         28: op = OP_POP_B;  29: op = OP_JNZ;    30: op = OP_JMP;    31: op = OP_PUSH_B;
         32: op = OP_ADI;    33: op = OP_RET;    34: op = OP_POP_D;  35: op = OP_OUT;
         36: op = OP_PUSH_D; 37: op = OP_SBI;    38: op = OP_POP_H;  39: op = OP_PUSH_H;
         40: op = OP_DI;     41: op = OP_SPHL;   42: op = OP_EI;     43: op = OP_JNZ;
         44: op = OP_ADD_B + 8'($urandom_range(0, 7));
         45: op = OP_SUB_B + 8'($urandom_range(0, 7));
         46: op = OP_ANA_B + 8'($urandom_range(0, 7));
         default: begin
            op = 8'($urandom_range(0, 255));
            if (op == OP_HLT) op = OP_NOP;
         end
      endcase
      return op;
   endfunction

   function automatic int op_bytes(logic [7:0] op);
      case (op)
         OP_MVI_B, OP_MVI_C, OP_MVI_D, OP_MVI_E, OP_MVI_H, OP_MVI_L, OP_MVI_M, OP_MVI_A,
         OP_ADI, OP_SBI: return 2;
         OP_LXI_B, OP_LXI_D, OP_LXI_H, OP_LXI_SP, OP_STA, OP_JMP, OP_JNZ: return 3;
         default: return 1;
      endcase
   endfunction

   // load a random program, jump to it, set its length and step through it
   task automatic run_program();
      int          size, n, len_sel, plen;
      logic [15:0] base, start, tgt;
      logic [7:0]  op, b1;
      program_count++;
      fast_mode = ($urandom_range(0, 3) == 0);
      size = $urandom_range(4, 24);
      base = ($urandom_range(0, 7) == 0) ? 16'hFFF0 + 16'($urandom_range(0, 15))
                                         : 16'($urandom_range(16'h0040, 16'hFF00));
      write_len(65536);
      if ($urandom_range(0, 9) == 0) hold_rsp = 1'b1;
      start = last_pc;
      send(CMD_LOAD, start, OP_JMP);
      send(CMD_LOAD, start + 16'd1, base[7:0]);
      send(CMD_LOAD, start + 16'd2, base[15:8]);
      n = 0;
      while (n < size) begin
         op = pick_op();
         send(CMD_LOAD, base + 16'(n), op);
         if (op_bytes(op) >= 2) begin
            b1 = 8'($urandom_range(0, 255));
            // keep most jumps inside the program
            if ((op == OP_JMP || op == OP_JNZ) && $urandom_range(0, 3) != 0)
               tgt = base + 16'($urandom_range(0, size - 1));
            else
               tgt = 16'($urandom_range(0, 65535));
            if (op_bytes(op) == 3) begin
               send(CMD_LOAD, base + 16'(n + 1), tgt[7:0]);
               send(CMD_LOAD, base + 16'(n + 2), tgt[15:8]);
            end else begin
               send(CMD_LOAD, base + 16'(n + 1), b1);
            end
         end
         n += op_bytes(op);
      end
      send(CMD_STEP, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
      len_sel = $urandom_range(0, 9);
      case (len_sel)
         0: plen = 0;
         1: plen = 65536;
         2: plen = base;
         3: plen = 1;
         default: plen = (int'(base) + n > 65536) ? 65536 : int'(base) + n;
      endcase
      write_len(plen);
      repeat (n + 4)
         send(CMD_STEP, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
   endtask

   // result side
   initial begin
      int stall;
      rsp_chan.ready <= 1'b0;
      recv_count = 0;
      last_pc = '0;
      forever begin
         if (hold_rsp) begin
            rsp_chan.ready <= 1'b0;
            repeat (300) @(posedge clock);
            hold_rsp = 1'b0;
         end
         stall = fast_mode ? 0 : $urandom_range(0, 16);
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
         recv_count++;
         last_pc = rsp_chan.prog_counter;
      end
   end

   initial begin
      req_chan.valid     <= 1'b0;
      req_chan.cmd       <= CMD_LOAD;
      req_chan.address   <= '0;
      req_chan.data_byte <= '0;
      csr_wr_en          <= 1'b0;
      csr_wr_data        <= '0;
      sent_count = 0;
      program_count = 0;
      fast_mode = 1'b0;
      hold_rsp = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // empty program: a step ends at once; loads at the address and data extremes
      write_len(0);
      send(CMD_STEP, 16'hFFFF, 8'hFF);
      send(CMD_LOAD, 16'hFFFF, 8'hFF);
      send(CMD_LOAD, 16'h0000, 8'h00);
      send(CMD_LOAD, 16'h5555, 8'hAA);
      send(CMD_LOAD, 16'hAAAA, 8'h55);
      send(CMD_STEP, 16'h0000, 8'h00);
      // long receiver stall while loads keep coming
      hold_rsp = 1'b1;
      repeat (12) send(CMD_LOAD, 16'($urandom_range(16'h0100, 16'hFFFF)),
                       8'($urandom_range(0, 255)));

      while (sent_count < 1650) run_program();

      // halt: further steps report halted, loads still go through
      write_len(65536);
      send(CMD_LOAD, last_pc, OP_HLT);
      send(CMD_STEP, 16'h0000, 8'h00);
      repeat (4) send(CMD_STEP, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
      send(CMD_LOAD, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
      send(CMD_STEP, 16'hFFFF, 8'hFF);
      settle();
      repeat (20) @(posedge clock);

      $display("Ran %0d random programs, %0d transfers in, %0d results checked.",
               program_count, sent_count, checked_count);
      $display("Covered empty and full-range program lengths, address wrap and halt.");
      if (err_count == 0)
         $display("[cpu_8080_subset_core] OK");
      else
         $display("[cpu_8080_subset_core] ERROR");
      $finish;
   end

endmodule
